>>> sv/pfa_pkg.sv
// ----------------------------------------------------------------------------
// pfa_pkg
// Shared types and codes of the page frame allocator.
// ----------------------------------------------------------------------------
package pfa_pkg;

  localparam int VIRT_W  = 36;
  localparam int COUNT_W = 17;
  localparam int INDEX_W = 16;
  localparam int CFG_W   = 17;
  localparam int WORD_W  = 64;

  localparam logic [2:0] OP_ALLOC     = 3'd0;
  localparam logic [2:0] OP_FREE      = 3'd1;
  localparam logic [2:0] OP_MARK_USER = 3'd2;
  localparam logic [2:0] OP_MARK_KERN = 3'd3;
  localparam logic [2:0] OP_PICK      = 3'd4;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NO_FREE = 2'd1;
  localparam logic [1:0] ST_RANGE   = 2'd2;
  localparam logic [1:0] ST_NO_USER = 2'd3;

  localparam logic CFG_PAGE_COUNT  = 1'b0;
  localparam logic CFG_FIRST_USABLE = 1'b1;

  localparam logic [30:0] LCG_MUL = 31'd1103515245;
  localparam logic [63:0] LCG_ADD = 64'd12345;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  typedef struct packed {
    logic [2:0]         opcode;
    logic [INDEX_W-1:0] page_index;
    logic [VIRT_W-1:0]  virt_page;
  } req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [INDEX_W-1:0] page_out;
    logic [VIRT_W-1:0]  virt_page_out;
    logic [COUNT_W-1:0] free_count;
    logic [COUNT_W-1:0] in_use_count;
  } rsp_t;

  typedef struct packed {
    logic       latch;
    logic       clr_step;
    logic       scan_init;
    logic       scan_next;
    logic       rd_free;
    logic       alloc_commit;
    logic       free_commit;
    logic       mark_commit;
    logic       tries_init;
    logic       try_next;
    logic       mul0;
    logic       mul1;
    logic       lcg_add;
    logic       div_step;
    logic       pick_hit;
    logic       set_status;
    logic [1:0] status;
    logic       res_load;
  } cmd_t;

  typedef struct packed {
    logic [2:0] opcode;
    logic       clear_done;
    logic       free_err;
    logic       mark_err;
    logic       n_zero;
    logic       scan_past;
    logic       scan_hit;
    logic       scan_last;
    logic       div_last;
    logic       virt_hit;
    logic       tries_last;
    logic       out_free;
  } sts_t;

endpackage

>>> sv/pfa_ram.sv
// ----------------------------------------------------------------------------
// pfa_ram
// Simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module pfa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> sv/pfa_ctrl.sv
// ----------------------------------------------------------------------------
// pfa_ctrl
// Sequencer: clearing pass, request decode, scan, release, random pick.
// ----------------------------------------------------------------------------
module pfa_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  pfa_pkg::sts_t sts,
  output pfa_pkg::cmd_t cmd
);
  import pfa_pkg::*;

  typedef enum logic [16:0] {
    S_CLEAR = 17'b00000000000000001,
    S_IDLE  = 17'b00000000000000010,
    S_DEC   = 17'b00000000000000100,
    S_ARD   = 17'b00000000000001000,
    S_ACHK  = 17'b00000000000010000,
    S_FRD   = 17'b00000000000100000,
    S_FWR   = 17'b00000000001000000,
    S_MUL0  = 17'b00000000010000000,
    S_MUL1  = 17'b00000000100000000,
    S_ADD   = 17'b00000001000000000,
    S_DIV   = 17'b00000010000000000,
    S_VRD   = 17'b00000100000000000,
    S_VCHK  = 17'b00001000000000000,
    S_DONE  = 17'b00010000000000000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clear_done) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        cmd.set_status = 1'b1;
        cmd.status     = ST_OK;
        state_nxt      = S_DONE;
        unique case (sts.opcode)
          OP_ALLOC: begin
            cmd.scan_init = 1'b1;
            state_nxt     = S_ARD;
          end
          OP_FREE: begin
            if (sts.free_err) begin
              cmd.status = ST_RANGE;
            end else begin
              state_nxt = S_FRD;
            end
          end
          OP_MARK_USER, OP_MARK_KERN: begin
            if (sts.mark_err) begin
              cmd.status = ST_RANGE;
            end else begin
              cmd.mark_commit = 1'b1;
            end
          end
          OP_PICK: begin
            if (sts.n_zero) begin
              cmd.status = ST_NO_USER;
            end else begin
              cmd.tries_init = 1'b1;
              state_nxt      = S_MUL0;
            end
          end
          default: ;
        endcase
      end
      S_ARD: begin
        if (sts.scan_past) begin
          cmd.set_status = 1'b1;
          cmd.status     = ST_NO_FREE;
          state_nxt      = S_DONE;
        end else begin
          state_nxt = S_ACHK;
        end
      end
      S_ACHK: begin
        if (sts.scan_hit) begin
          cmd.alloc_commit = 1'b1;
          state_nxt        = S_DONE;
        end else if (sts.scan_last) begin
          cmd.set_status = 1'b1;
          cmd.status     = ST_NO_FREE;
          state_nxt      = S_DONE;
        end else begin
          cmd.scan_next = 1'b1;
          state_nxt     = S_ARD;
        end
      end
      S_FRD: begin
        cmd.rd_free = 1'b1;
        state_nxt   = S_FWR;
      end
      S_FWR: begin
        cmd.free_commit = 1'b1;
        state_nxt       = S_DONE;
      end
      S_MUL0: begin
        cmd.mul0  = 1'b1;
        state_nxt = S_MUL1;
      end
      S_MUL1: begin
        cmd.mul1  = 1'b1;
        state_nxt = S_ADD;
      end
      S_ADD: begin
        cmd.lcg_add = 1'b1;
        state_nxt   = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = S_VRD;
        end
      end
      S_VRD: begin
        state_nxt = S_VCHK;
      end
      S_VCHK: begin
        if (sts.virt_hit) begin
          cmd.pick_hit   = 1'b1;
          cmd.set_status = 1'b1;
          cmd.status     = ST_OK;
          state_nxt      = S_DONE;
        end else if (sts.tries_last) begin
          cmd.set_status = 1'b1;
          cmd.status     = ST_NO_USER;
          state_nxt      = S_DONE;
        end else begin
          cmd.try_next = 1'b1;
          state_nxt    = S_MUL0;
        end
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.res_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_CLEAR;
    endcase
  end
endmodule

>>> sv/pfa_dp.sv
// ----------------------------------------------------------------------------
// pfa_dp
// Datapath: core map memories, counts, generator, remainder unit, result.
// ----------------------------------------------------------------------------
module pfa_dp #(
  parameter int PAGES        = 65536,
  parameter int RANDOM_TRIES = 100
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  pfa_pkg::req_t                in_data,
  input  logic                         out_ready,
  output logic                         out_valid,
  output pfa_pkg::rsp_t                out_data,
  input  logic                         cfg_we,
  input  logic                         cfg_index,
  input  logic [pfa_pkg::CFG_W-1:0]    cfg_data,
  input  pfa_pkg::cmd_t                cmd,
  output pfa_pkg::sts_t                sts
);
  import pfa_pkg::*;

  localparam int PW    = $clog2(PAGES);
  localparam int NW    = PW + 1;
  localparam int WORDS = (PAGES + WORD_W - 1) / WORD_W;
  localparam int WAW   = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int XW    = (PW + 8 > 18) ? PW + 8 : 18;
  localparam int TW    = $clog2(RANDOM_TRIES + 1);

  logic [CFG_W-1:0]   page_count_r;
  logic [INDEX_W-1:0] first_r;
  req_t               req_r;
  logic [PW-1:0]      clr_r;
  logic [WAW-1:0]     scan_w_r;
  logic [1:0]         status_r;
  logic [INDEX_W-1:0] page_r;
  logic [VIRT_W-1:0]  virt_r;
  logic [COUNT_W-1:0] free_r, used_r;
  logic [63:0]        lcg_r, lcg_nxt;
  logic [62:0]        p0_r, p0_nxt;
  logic [31:0]        p1_r, p1_nxt;
  logic [31:0]        q_r;
  logic [NW-1:0]      rem_r, rem_nxt;
  logic [4:0]         div_cnt_r;
  logic [TW-1:0]      tries_r;
  rsp_t               out_r;
  logic               out_valid_r;

  logic [XW-1:0] n_x, idx_x, first_x, base_x, rem_x, pc_x;
  logic [NW-1:0] n;
  logic [PW-1:0] idx_p;
  logic [WAW-1:0] idx_w;
  logic [WORD_W-1:0] mask, scan_word, av_rdata, av_wdata;
  logic [5:0]    bit_sel;
  logic [NW:0]   div_sh;
  logic          div_ge;
  logic          av_we, vt_we;
  logic [WAW-1:0] av_waddr, av_raddr;
  logic [PW-1:0]  vt_waddr;
  logic [VIRT_W-1:0] vt_wdata, vt_rdata;
  logic          free_was;

  assign pc_x   = XW'(page_count_r);
  assign n_x    = (pc_x < XW'(PAGES)) ? pc_x : XW'(PAGES);
  assign n      = NW'(n_x);
  assign idx_x  = XW'(req_r.page_index);
  assign first_x = XW'(first_r);
  assign idx_p  = PW'(req_r.page_index);
  assign idx_w  = WAW'(idx_p >> 6);
  assign base_x = XW'({scan_w_r, 6'b0});
  assign rem_x  = n_x - base_x;
  assign mask   = (rem_x >= XW'(WORD_W)) ? '1 : ((64'd1 << rem_x[5:0]) - 64'd1);
  assign scan_word = av_rdata & mask;

  always_comb begin
    bit_sel = '0;
    for (int b = WORD_W - 1; b >= 0; b--) begin
      if (scan_word[b]) begin
        bit_sel = 6'(b);
      end
    end
  end

  assign free_was = av_rdata[req_r.page_index[5:0]];

  assign sts.opcode     = req_r.opcode;
  assign sts.clear_done = (clr_r == PW'(PAGES - 1));
  assign sts.free_err   = (idx_x < first_x) || (idx_x >= n_x);
  assign sts.mark_err   = (idx_x >= n_x);
  assign sts.n_zero     = (n_x == '0);
  assign sts.scan_past  = (base_x >= n_x);
  assign sts.scan_hit   = |scan_word;
  assign sts.scan_last  = (scan_w_r == WAW'(WORDS - 1));
  assign sts.div_last   = (div_cnt_r == 5'd31);
  assign sts.virt_hit   = (vt_rdata != '0);
  assign sts.tries_last = (tries_r == TW'(RANDOM_TRIES - 1));
  assign sts.out_free   = !out_valid_r || out_ready;

  always_comb begin
    av_we    = 1'b0;
    av_waddr = scan_w_r;
    av_wdata = '0;
    if (cmd.clr_step) begin
      av_we    = XW'(clr_r) < XW'(WORDS);
      av_waddr = WAW'(clr_r);
    end else if (cmd.alloc_commit) begin
      av_we    = 1'b1;
      av_wdata = av_rdata & ~(64'd1 << bit_sel);
    end else if (cmd.free_commit) begin
      av_we    = 1'b1;
      av_waddr = idx_w;
      av_wdata = av_rdata | (64'd1 << req_r.page_index[5:0]);
    end
  end

  assign av_raddr = cmd.rd_free ? idx_w : scan_w_r;

  always_comb begin
    vt_we    = 1'b0;
    vt_waddr = idx_p;
    vt_wdata = '0;
    if (cmd.clr_step) begin
      vt_we    = 1'b1;
      vt_waddr = clr_r;
    end else if (cmd.free_commit) begin
      vt_we = 1'b1;
    end else if (cmd.mark_commit) begin
      vt_we    = 1'b1;
      vt_wdata = (req_r.opcode == OP_MARK_USER) ? req_r.virt_page : '0;
    end
  end

  pfa_ram #(.WIDTH(WORD_W), .DEPTH(WORDS)) u_avail (
    .clk(clk), .we(av_we), .waddr(av_waddr), .wdata(av_wdata),
    .raddr(av_raddr), .rdata(av_rdata)
  );

  pfa_ram #(.WIDTH(VIRT_W), .DEPTH(PAGES)) u_virt (
    .clk(clk), .we(vt_we), .waddr(vt_waddr), .wdata(vt_wdata),
    .raddr(PW'(rem_r)), .rdata(vt_rdata)
  );

  assign p0_nxt  = lcg_r[31:0] * LCG_MUL;
  assign p1_nxt  = lcg_r[63:32] * LCG_MUL;
  assign lcg_nxt = 64'(p0_r) + {p1_r, 32'b0} + LCG_ADD;
  assign div_sh  = {rem_r, q_r[31]};
  assign div_ge  = div_sh >= {1'b0, n};
  assign rem_nxt = div_ge ? NW'(div_sh - {1'b0, n}) : NW'(div_sh);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      page_count_r <= CFG_W'(65536);
      first_r      <= '0;
      clr_r        <= '0;
      free_r       <= '0;
      used_r       <= '0;
      lcg_r        <= 64'd1;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_PAGE_COUNT:   page_count_r <= cfg_data;
          CFG_FIRST_USABLE: first_r      <= cfg_data[INDEX_W-1:0];
          default: ;
        endcase
      end
      if (cmd.clr_step && !sts.clear_done) begin
        clr_r <= clr_r + PW'(1);
      end
      if (cmd.alloc_commit) begin
        used_r <= (used_r == COUNT_MAX) ? used_r : used_r + COUNT_W'(1);
        free_r <= (free_r == '0) ? free_r : free_r - COUNT_W'(1);
      end
      if (cmd.free_commit && !free_was) begin
        used_r <= (used_r == '0) ? used_r : used_r - COUNT_W'(1);
        free_r <= (free_r == COUNT_MAX) ? free_r : free_r + COUNT_W'(1);
      end
      if (cmd.lcg_add) begin
        lcg_r <= lcg_nxt;
      end
      if (cmd.res_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      req_r  <= in_data;
      page_r <= '0;
      virt_r <= '0;
    end
    if (cmd.set_status) begin
      status_r <= cmd.status;
    end
    if (cmd.scan_init) begin
      scan_w_r <= '0;
    end else if (cmd.scan_next) begin
      scan_w_r <= scan_w_r + WAW'(1);
    end
    if (cmd.alloc_commit) begin
      status_r <= ST_OK;
      page_r   <= INDEX_W'(base_x + XW'(bit_sel));
    end
    if (cmd.pick_hit) begin
      page_r <= INDEX_W'(rem_r);
      virt_r <= vt_rdata;
    end
    if (cmd.tries_init) begin
      tries_r <= '0;
    end else if (cmd.try_next) begin
      tries_r <= tries_r + TW'(1);
    end
    if (cmd.mul0) begin
      p0_r <= p0_nxt;
    end
    if (cmd.mul1) begin
      p1_r <= p1_nxt;
    end
    if (cmd.lcg_add) begin
      q_r       <= lcg_nxt[47:16];
      rem_r     <= '0;
      div_cnt_r <= '0;
    end else if (cmd.div_step) begin
      q_r       <= {q_r[30:0], 1'b0};
      rem_r     <= rem_nxt;
      div_cnt_r <= div_cnt_r + 5'd1;
    end
    if (cmd.res_load) begin
      out_r.status        <= status_r;
      out_r.page_out      <= page_r;
      out_r.virt_page_out <= virt_r;
      out_r.free_count    <= free_r;
      out_r.in_use_count  <= used_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;
endmodule

>>> sv/page_frame_allocator.sv
// ----------------------------------------------------------------------------
// page_frame_allocator
// Physical page frame allocator with a per-page core map.
//
//   port group | direction | handshake
//   in_        | request   | in_valid / in_ready, payload in_data
//   out_       | result    | out_valid / out_ready, payload out_data
//   cfg_       | config    | cfg_we, cfg_index, cfg_data
//
// After reset a clearing pass over all PAGES entries zeroes the core map;
// no request is taken until it ends. Allocate checks each 64-page word of
// the availability memory in turn until one holds a free page. Random pick
// makes draws of 3 multiply/add steps, 32 remainder steps, 1 memory read
// and 1 check, up to RANDOM_TRIES draws.
// A result waits in the output register while out_ready is low.
// ----------------------------------------------------------------------------
module page_frame_allocator #(
  parameter int PAGES        = 65536,
  parameter int RANDOM_TRIES = 100
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  pfa_pkg::req_t             in_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output pfa_pkg::rsp_t             out_data,
  input  logic                      cfg_we,
  input  logic                      cfg_index,
  input  logic [pfa_pkg::CFG_W-1:0] cfg_data
);
  import pfa_pkg::*;

  cmd_t cmd;
  sts_t sts;

  pfa_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .sts(sts), .cmd(cmd)
  );

  pfa_dp #(.PAGES(PAGES), .RANDOM_TRIES(RANDOM_TRIES)) u_dp (
    .clk(clk), .rst_n(rst_n), .in_data(in_data), .out_ready(out_ready),
    .out_valid(out_valid), .out_data(out_data), .cfg_we(cfg_we),
    .cfg_index(cfg_index), .cfg_data(cfg_data), .cmd(cmd), .sts(sts)
  );
endmodule

>>> sv/pfa_checker.sv
// ----------------------------------------------------------------------------
// pfa_checker
// Port-level checks of the page frame allocator.
// ----------------------------------------------------------------------------
module pfa_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          in_valid,
  input logic          in_ready,
  input logic          out_valid,
  input logic          out_ready,
  input pfa_pkg::rsp_t out_data
);
  import pfa_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result dropped or changed while stalled");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while busy");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != ST_OK |->
      out_data.page_out == '0 && out_data.virt_page_out == '0)
    else $error("error result carries a page");

  a_reset_idle: assert property (@(posedge clk)
    rst_n && !$past(rst_n) |-> !out_valid && !in_ready)
    else $error("activity right after reset");
endmodule

bind page_frame_allocator pfa_checker u_pfa_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);
